[rtl/spr_pkg.sv]
// Shared types and constants for the stereo sample player.
// Used by every module of the block; no dependencies.
package spr_pkg;

   localparam int FRAME_DEPTH = 262144;
   localparam int ADDR_W      = 18;
   localparam int POS_W       = 35;
   localparam int MAX_BLOCK   = 4096;
   localparam int DIV_W       = 48;
   localparam int DIVISOR_W   = 20;
   localparam int ROOT_W      = DIV_W / 2;

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_TICK  = 2'd1,
      ACT_SEEK  = 2'd2,
      ACT_FADE  = 2'd3
   } action_type;

   localparam logic [1:0] TR_STOPPED  = 2'd0;
   localparam logic [1:0] TR_STARTING = 2'd1;
   localparam logic [1:0] TR_PLAYING  = 2'd2;
   localparam logic [1:0] TR_STOPPING = 2'd3;

   localparam logic [2:0] REG_RATIO   = 3'd0;
   localparam logic [2:0] REG_DECODED = 3'd1;
   localparam logic [2:0] REG_TOTAL   = 3'd2;
   localparam logic [2:0] REG_LOADED  = 3'd3;
   localparam logic [2:0] REG_FADE    = 3'd4;

   typedef struct packed {
      logic [1:0]         action;
      logic [17:0]        frame_index;
      logic signed [15:0] sample_left;
      logic signed [15:0] sample_right;
      logic [1:0]         transport;
      logic               has_track;
      logic [15:0]        gain;
      logic [19:0]        fade_length;
      logic               last_in_block;
   } req_type;

   typedef struct packed {
      logic signed [15:0] out_left;
      logic signed [15:0] out_right;
      logic [14:0]        block_rms;
      logic [14:0]        block_peak;
      logic               block_end;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_W-1:0]     dividend;
      logic [DIVISOR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } sqrt_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_ENV_DIV,
      ST_RD_A,
      ST_RD_B,
      ST_INTERP,
      ST_GAIN,
      ST_ENV_MUL,
      ST_ACCUM,
      ST_MEAN_DIV,
      ST_SQRT,
      ST_OUT
   } state_type;

endpackage

[rtl/spr_frame_ram.sv]
// Stereo frame memory: one write port, one read port, registered read data.
// Depends on spr_pkg.
module spr_frame_ram (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [spr_pkg::ADDR_W-1:0] wr_addr,
   input  logic [31:0]               wr_data,
   input  logic                      rd_en,
   input  logic [spr_pkg::ADDR_W-1:0] rd_addr,
   output logic [31:0]               rd_data
);

   logic [31:0] mem [spr_pkg::FRAME_DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/spr_divider.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on spr_pkg.
module spr_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  spr_pkg::div_req_type req,
   output spr_pkg::div_rsp_type rsp
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [5:0]                     cnt_ff, cnt_in;
   logic [spr_pkg::DIV_W-1:0]      quo_ff, quo_in;
   logic [spr_pkg::DIVISOR_W:0]    rem_ff, rem_in;
   logic [spr_pkg::DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [spr_pkg::DIVISOR_W+1:0]  trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, quo_ff[spr_pkg::DIV_W-1]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 6'(spr_pkg::DIV_W);
         quo_in  = req.dividend;
         rem_in  = '0;
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         if (trial >= {2'b00, dsr_ff}) begin
            rem_in = (spr_pkg::DIVISOR_W+1)'(trial - {2'b00, dsr_ff});
            quo_in = {quo_ff[spr_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = (spr_pkg::DIVISOR_W+1)'(trial);
            quo_in = {quo_ff[spr_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

[rtl/spr_isqrt.sv]
// Integer square root, one root bit per cycle (digit by digit).
// Depends on spr_pkg.
module spr_isqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  spr_pkg::sqrt_req_type req,
   output spr_pkg::sqrt_rsp_type rsp
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [4:0]                  cnt_ff, cnt_in;
   logic [spr_pkg::DIV_W-1:0]   val_ff, val_in;
   logic [spr_pkg::ROOT_W-1:0]  root_ff, root_in;
   logic [spr_pkg::ROOT_W+2:0]  rem_ff, rem_in;
   logic [spr_pkg::ROOT_W+2:0]  shifted;
   logic [spr_pkg::ROOT_W+2:0]  trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      shifted = {rem_ff[spr_pkg::ROOT_W:0], val_ff[spr_pkg::DIV_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 5'(spr_pkg::ROOT_W);
         val_in  = req.radicand;
         root_in = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         val_in = {val_ff[spr_pkg::DIV_W-3:0], 2'b00};
         if (shifted >= trial) begin
            rem_in  = shifted - trial;
            root_in = {root_ff[spr_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted;
            root_in = {root_ff[spr_pkg::ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      val_ff  <= val_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
   end

   assign rsp.done = done_ff;
   assign rsp.root = root_ff;

endmodule

[rtl/sample_player_resampler.sv]
// Stereo sample player with linear-interpolation resampling, stop fade and
// block metering. Write, seek and fade words are taken in idle and give
// no result. A tick word runs through the state machine, with an envelope
// divide in the shared divider when a stop fade is running, and on a block's
// last tick with audio loaded a mean divide and the 24-step square root.
// Frames are read one per cycle through the frame memory's read port. A finished
// result waits in the output register while the next word is taken.
// Depends on spr_pkg, spr_frame_ram, spr_divider, spr_isqrt.
module sample_player_resampler (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  spr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spr_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [23:0]      csr_data
);

   spr_pkg::state_type state_ff, state_in;

   // configuration
   logic [23:0] ratio_ff;
   logic [18:0] decoded_ff;
   logic [18:0] total_ff;
   logic        loaded_ff;

   // player state
   logic [spr_pkg::POS_W-1:0] pos_ff;
   logic [19:0] fade_rem_ff;
   logic [19:0] fade_tot_ff;
   logic [47:0] sum_ff;
   logic [14:0] peak_ff;
   logic [12:0] count_ff;

   // tick working registers
   spr_pkg::req_type tick_ff;
   logic               present_ff;
   logic               run_ff;
   logic [16:0]        env_ff;
   logic [spr_pkg::ADDR_W-1:0] nxt_ff;
   logic signed [15:0] a_l_ff, a_r_ff;
   logic [31:0]        mag_l_ff, mag_r_ff;
   logic               neg_l_ff, neg_r_ff;
   logic [31:0]        m1_l_ff, m1_r_ff;
   logic signed [15:0] vl_ff, vr_ff;
   logic               ending_ff;
   logic [14:0]        rms_ff;
   logic [14:0]        peak_rep_ff;

   logic             rsp_valid_ff;
   spr_pkg::rsp_type rsp_data_ff;

   // combinational
   logic        req_acc, csr_acc;
   logic [18:0] ipos, bound, ipos_p1;
   logic        active, stop_fade, run;
   logic [19:0] rem_clamp;
   logic [31:0] ram_rd_data;
   logic        ram_rd_en, ram_wr_en;
   logic [spr_pkg::ADDR_W-1:0] ram_rd_addr;
   spr_pkg::div_req_type  div_req;
   spr_pkg::div_rsp_type  div_rsp;
   spr_pkg::sqrt_req_type sqrt_req;
   spr_pkg::sqrt_rsp_type sqrt_rsp;
   logic        out_free;
   logic [15:0] abs_l, abs_r;
   logic [16:0] mono_sum;
   logic [14:0] mono;
   logic [47:0] sum_in;
   logic [14:0] peak_in;
   logic [12:0] count_in;
   logic        ending_in;
   logic signed [34:0] interp_l, interp_r;
   logic [47:0] g_l, g_r;
   logic [48:0] e_l, e_r;
   logic [18:0] r_l, r_r;
   logic signed [15:0] sat_l, sat_r;
   logic [19:0] fade_len;

   assign req_acc  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_acc  = csr_valid && csr_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign ipos    = pos_ff[spr_pkg::POS_W-1:16];
   assign bound   = decoded_ff[18] ? 19'(spr_pkg::FRAME_DEPTH) : decoded_ff;
   assign ipos_p1 = ipos + 19'd1;
   assign stop_fade = tick_ff.transport == spr_pkg::TR_STOPPING && fade_rem_ff != '0;
   assign active  = tick_ff.transport == spr_pkg::TR_STARTING ||
                    tick_ff.transport == spr_pkg::TR_PLAYING || stop_fade;
   assign run     = present_ff && tick_ff.has_track && active && ipos < bound;
   assign rem_clamp = fade_rem_ff <= fade_tot_ff ? fade_rem_ff : fade_tot_ff;
   assign fade_len  = req_data.fade_length == '0 ? 20'd1 : req_data.fade_length;

   // mono level and block accumulation
   always_comb begin
      abs_l    = vl_ff[15] ? 16'(-vl_ff) : 16'(vl_ff);
      abs_r    = vr_ff[15] ? 16'(-vr_ff) : 16'(vr_ff);
      mono_sum = 17'(abs_l) + 17'(abs_r) + 17'd1;
      mono     = mono_sum[16:1] > 16'd32767 ? 15'h7fff : mono_sum[15:1];
      sum_in   = sum_ff + 48'(mono * mono);
      peak_in  = mono > peak_ff ? mono : peak_ff;
      count_in = count_ff + 13'd1;
      ending_in = tick_ff.last_in_block || count_in >= 13'(spr_pkg::MAX_BLOCK);
   end

   // interpolation: a*65536 + (b-a)*frac
   always_comb begin
      interp_l = (35'(a_l_ff) <<< 16) + 35'((17'($signed(ram_rd_data[31:16])) -
                 17'(a_l_ff)) * $signed({1'b0, pos_ff[15:0]}));
      interp_r = (35'(a_r_ff) <<< 16) + 35'((17'($signed(ram_rd_data[15:0])) -
                 17'(a_r_ff)) * $signed({1'b0, pos_ff[15:0]}));
   end

   assign g_l = 48'(mag_l_ff) * 48'(tick_ff.gain) + 48'd32768;
   assign g_r = 48'(mag_r_ff) * 48'(tick_ff.gain) + 48'd32768;
   assign e_l = 49'(m1_l_ff) * 49'(env_ff) + 49'd536870912;
   assign e_r = 49'(m1_r_ff) * 49'(env_ff) + 49'd536870912;
   assign r_l = e_l[48:30];
   assign r_r = e_r[48:30];

   always_comb begin
      if (neg_l_ff) begin
         sat_l = r_l > 19'd32768 ? 16'sh8000 : 16'(-r_l);
      end else begin
         sat_l = r_l > 19'd32767 ? 16'sh7fff : 16'(r_l);
      end
      if (neg_r_ff) begin
         sat_r = r_r > 19'd32768 ? 16'sh8000 : 16'(-r_r);
      end else begin
         sat_r = r_r > 19'd32767 ? 16'sh7fff : 16'(r_r);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spr_pkg::ST_IDLE: begin
            if (req_acc && req_data.action == spr_pkg::ACT_TICK) begin
               state_in = spr_pkg::ST_CHECK;
            end
         end
         spr_pkg::ST_CHECK: begin
            if (present_ff && stop_fade) begin
               state_in = spr_pkg::ST_ENV_DIV;
            end else if (run) begin
               state_in = spr_pkg::ST_RD_A;
            end else begin
               state_in = spr_pkg::ST_ACCUM;
            end
         end
         spr_pkg::ST_ENV_DIV: begin
            if (div_rsp.done) begin
               state_in = run_ff ? spr_pkg::ST_RD_A : spr_pkg::ST_ACCUM;
            end
         end
         spr_pkg::ST_RD_A:    state_in = spr_pkg::ST_RD_B;
         spr_pkg::ST_RD_B:    state_in = spr_pkg::ST_INTERP;
         spr_pkg::ST_INTERP:  state_in = spr_pkg::ST_GAIN;
         spr_pkg::ST_GAIN:    state_in = spr_pkg::ST_ENV_MUL;
         spr_pkg::ST_ENV_MUL: state_in = spr_pkg::ST_ACCUM;
         spr_pkg::ST_ACCUM: begin
            state_in = (ending_in && present_ff) ? spr_pkg::ST_MEAN_DIV : spr_pkg::ST_OUT;
         end
         spr_pkg::ST_MEAN_DIV: begin
            if (div_rsp.done) begin
               state_in = spr_pkg::ST_SQRT;
            end
         end
         spr_pkg::ST_SQRT: begin
            if (sqrt_rsp.done) begin
               state_in = spr_pkg::ST_OUT;
            end
         end
         spr_pkg::ST_OUT: begin
            if (out_free) begin
               state_in = spr_pkg::ST_IDLE;
            end
         end
         default: state_in = spr_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready        = 1'b0;
      ram_rd_en        = 1'b0;
      ram_rd_addr      = ipos[spr_pkg::ADDR_W-1:0];
      div_req.start    = 1'b0;
      div_req.dividend = 48'({rem_clamp, 16'h0000});
      div_req.divisor  = fade_tot_ff;
      sqrt_req.start    = 1'b0;
      sqrt_req.radicand = div_rsp.quotient;
      unique case (state_ff)
         spr_pkg::ST_IDLE:  req_ready = 1'b1;
         spr_pkg::ST_CHECK: div_req.start = present_ff && stop_fade;
         spr_pkg::ST_RD_A:  ram_rd_en = 1'b1;
         spr_pkg::ST_RD_B: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = nxt_ff;
         end
         spr_pkg::ST_ACCUM: begin
            div_req.start    = ending_in && present_ff;
            div_req.dividend = sum_in;
            div_req.divisor  = 20'(count_in);
         end
         spr_pkg::ST_MEAN_DIV: sqrt_req.start = div_rsp.done;
         default: begin
         end
      endcase
   end

   assign ram_wr_en = req_acc && req_data.action == spr_pkg::ACT_WRITE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spr_pkg::ST_IDLE;
         ratio_ff     <= 24'd65536;
         decoded_ff   <= '0;
         total_ff     <= '0;
         loaded_ff    <= 1'b0;
         pos_ff       <= '0;
         fade_rem_ff  <= '0;
         fade_tot_ff  <= 20'd9600;
         sum_ff       <= '0;
         peak_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_acc) begin
            unique case (csr_index)
               spr_pkg::REG_RATIO:   ratio_ff   <= csr_data;
               spr_pkg::REG_DECODED: decoded_ff <= csr_data[18:0];
               spr_pkg::REG_TOTAL:   total_ff   <= csr_data[18:0];
               spr_pkg::REG_LOADED:  loaded_ff  <= csr_data[0];
               spr_pkg::REG_FADE: begin
                  fade_tot_ff <= csr_data[19:0] == '0 ? 20'd1 : csr_data[19:0];
                  fade_rem_ff <= '0;
               end
               default: begin
               end
            endcase
         end
         if (req_acc) begin
            if (req_data.action == spr_pkg::ACT_SEEK && loaded_ff) begin
               pos_ff <= {(19'(req_data.frame_index) < total_ff ?
                           19'(req_data.frame_index) : total_ff), 16'h0000};
            end
            if (req_data.action == spr_pkg::ACT_FADE) begin
               fade_tot_ff <= fade_len;
               fade_rem_ff <= fade_len;
            end
         end
         if (state_ff == spr_pkg::ST_CHECK && present_ff && stop_fade) begin
            fade_rem_ff <= fade_rem_ff - 20'd1;
         end
         if (state_ff == spr_pkg::ST_ENV_MUL) begin
            pos_ff <= pos_ff + 35'(ratio_ff);
         end
         if (state_ff == spr_pkg::ST_ACCUM) begin
            sum_ff   <= sum_in;
            peak_ff  <= peak_in;
            count_ff <= count_in;
         end
         if (state_ff == spr_pkg::ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
            if (ending_ff) begin
               sum_ff   <= '0;
               peak_ff  <= '0;
               count_ff <= '0;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         tick_ff    <= req_data;
         present_ff <= loaded_ff && total_ff != '0;
      end
      if (state_ff == spr_pkg::ST_CHECK) begin
         run_ff <= run;
         nxt_ff <= ipos_p1 < bound ? ipos_p1[spr_pkg::ADDR_W-1:0] :
                   spr_pkg::ADDR_W'(bound - 19'd1);
         env_ff <= active ? 17'd65536 : 17'd0;
         vl_ff  <= '0;
         vr_ff  <= '0;
         rms_ff <= '0;
         peak_rep_ff <= '0;
      end
      if (state_ff == spr_pkg::ST_ENV_DIV && div_rsp.done) begin
         env_ff <= div_rsp.quotient[16:0];
      end
      if (state_ff == spr_pkg::ST_RD_B) begin
         a_l_ff <= $signed(ram_rd_data[31:16]);
         a_r_ff <= $signed(ram_rd_data[15:0]);
      end
      if (state_ff == spr_pkg::ST_INTERP) begin
         neg_l_ff <= interp_l[34];
         neg_r_ff <= interp_r[34];
         mag_l_ff <= interp_l[34] ? 32'(-interp_l) : 32'(interp_l);
         mag_r_ff <= interp_r[34] ? 32'(-interp_r) : 32'(interp_r);
      end
      if (state_ff == spr_pkg::ST_GAIN) begin
         m1_l_ff <= g_l[47:16];
         m1_r_ff <= g_r[47:16];
      end
      if (state_ff == spr_pkg::ST_ENV_MUL) begin
         vl_ff <= sat_l;
         vr_ff <= sat_r;
      end
      if (state_ff == spr_pkg::ST_ACCUM) begin
         ending_ff   <= ending_in;
         peak_rep_ff <= (ending_in && present_ff) ? peak_in : 15'd0;
      end
      if (state_ff == spr_pkg::ST_SQRT && sqrt_rsp.done) begin
         rms_ff <= sqrt_rsp.root > 24'd32767 ? 15'h7fff : sqrt_rsp.root[14:0];
      end
      if (state_ff == spr_pkg::ST_OUT && out_free) begin
         rsp_data_ff.out_left   <= vl_ff;
         rsp_data_ff.out_right  <= vr_ff;
         rsp_data_ff.block_rms  <= rms_ff;
         rsp_data_ff.block_peak <= peak_rep_ff;
         rsp_data_ff.block_end  <= ending_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   spr_frame_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_data.frame_index),
      .wr_data ({req_data.sample_left, req_data.sample_right}),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   spr_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   spr_isqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (sqrt_req),
      .rsp   (sqrt_rsp)
   );

endmodule

[rtl/spr_checker.sv]
// Port-level checks for sample_player_resampler, bound to the top level.
// Depends on spr_pkg.
module spr_port_checks (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input spr_pkg::rsp_type rsp_data
);

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // meter fields stay zero off the block end
   a_meter_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.block_end |->
         rsp_data.block_rms == 15'd0 && rsp_data.block_peak == 15'd0)
      else $error("meter reported outside block end");

   // rms never exceeds peak
   a_rms_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.block_end |-> rsp_data.block_rms <= rsp_data.block_peak)
      else $error("block rms above block peak");

   // no result word right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind sample_player_resampler spr_port_checks u_port_checks (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[test/spr_checker.sv]
// Scoreboard for the stereo sample player: watches the word, result and register
// channels, predicts every result and compares it field by field.
// Depends on spr_pkg.
module spr_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  spr_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  spr_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [23:0]      csr_data,
   output int               mismatches,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic signed [15:0] left_mem [spr_pkg::FRAME_DEPTH];
   logic signed [15:0] right_mem [spr_pkg::FRAME_DEPTH];

   logic [23:0] ratio;
   logic [18:0] decoded;
   logic [18:0] total;
   logic        loaded;

   logic [spr_pkg::POS_W-1:0] play_pos;
   logic [19:0]      fade_left;
   logic [19:0]      fade_len;
   longint unsigned  sum_squares;
   int unsigned      peak_level;
   int unsigned      tick_count;

   spr_pkg::rsp_type expected_results [$];

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r, t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   // scale a Q.31 interpolation by Q2.14 gain and Q.16 envelope, round, saturate
   function automatic logic signed [15:0] scale_level(longint interp, logic [15:0] g,
                                                      longint unsigned env);
      longint unsigned m;
      m = (interp < 0) ? longint'(-interp) : longint'(interp);
      m = (m * g + 64'd32768) >> 16;
      m = (m * env + (64'd1 << 29)) >> 30;
      if (interp < 0) begin
         if (m > 32768) m = 32768;
         return 16'(-longint'(m));
      end
      if (m > 32767) m = 32767;
      return 16'(m);
   endfunction

   task automatic clear_state();
      ratio = 24'd65536;
      decoded = '0;
      total = '0;
      loaded = 1'b0;
      play_pos = '0;
      fade_left = '0;
      fade_len = 20'd9600;
      sum_squares = 0;
      peak_level = 0;
      tick_count = 0;
      expected_results.delete();
   endtask

   task automatic write_reg(logic [2:0] idx, logic [23:0] value);
      case (idx)
         spr_pkg::REG_RATIO:   ratio = value;
         spr_pkg::REG_DECODED: decoded = value[18:0];
         spr_pkg::REG_TOTAL:   total = value[18:0];
         spr_pkg::REG_LOADED:  loaded = value[0];
         spr_pkg::REG_FADE: begin
            fade_len = (value[19:0] == 0) ? 20'd1 : value[19:0];
            fade_left = '0;
         end
         default: ;
      endcase
   endtask

   task automatic play_tick(spr_pkg::req_type w);
      spr_pkg::rsp_type r;
      logic signed [15:0] vl, vr;
      bit active, ending;
      longint unsigned env, bound, ipos, nxt, frac, rem;
      longint il, ir;
      int unsigned al, ar, mono;
      vl = '0;
      vr = '0;
      r = '0;
      if (loaded && total != 0) begin
         active = 0;
         env = 0;
         if (w.transport == spr_pkg::TR_STARTING || w.transport == spr_pkg::TR_PLAYING) begin
            active = 1;
            env = 65536;
         end else if (w.transport == spr_pkg::TR_STOPPING && fade_left != 0) begin
            rem = (fade_left <= fade_len) ? fade_left : fade_len;
            active = 1;
            env = (rem << 16) / fade_len;
            fade_left = fade_left - 1;
         end
         if (w.has_track && active) begin
            bound = (decoded < spr_pkg::FRAME_DEPTH) ? decoded : spr_pkg::FRAME_DEPTH;
            ipos = play_pos >> 16;
            if (ipos < bound) begin
               frac = play_pos[15:0];
               nxt = (ipos + 1 < bound) ? ipos + 1 : bound - 1;
               il = longint'(left_mem[ipos]) * longint'(65536 - frac)
                  + longint'(left_mem[nxt]) * longint'(frac);
               ir = longint'(right_mem[ipos]) * longint'(65536 - frac)
                  + longint'(right_mem[nxt]) * longint'(frac);
               vl = scale_level(il, w.gain, env);
               vr = scale_level(ir, w.gain, env);
               play_pos = play_pos + ratio;
            end
         end
         al = (vl < 0) ? -int'(vl) : int'(vl);
         ar = (vr < 0) ? -int'(vr) : int'(vr);
         mono = (al + ar + 1) >> 1;
         if (mono > 32767) mono = 32767;
         sum_squares += longint'(mono) * mono;
         if (mono > peak_level) peak_level = mono;
         tick_count++;
         ending = w.last_in_block || tick_count >= spr_pkg::MAX_BLOCK;
         if (ending) begin
            rem = root_floor(sum_squares / tick_count);
            r.block_rms = (rem > 32767) ? 15'd32767 : 15'(rem);
            r.block_peak = 15'(peak_level);
         end
      end else begin
         tick_count++;
         ending = w.last_in_block || tick_count >= spr_pkg::MAX_BLOCK;
      end
      if (ending) begin
         sum_squares = 0;
         peak_level = 0;
         tick_count = 0;
      end
      r.out_left = vl;
      r.out_right = vr;
      r.block_end = ending;
      expected_results.push_back(r);
   endtask

   task automatic take_word(spr_pkg::req_type w);
      logic [18:0] f;
      case (spr_pkg::action_type'(w.action))
         spr_pkg::ACT_WRITE: begin
            left_mem[w.frame_index] = w.sample_left;
            right_mem[w.frame_index] = w.sample_right;
         end
         spr_pkg::ACT_SEEK: if (loaded) begin
            f = (w.frame_index < total) ? w.frame_index : total;
            play_pos = spr_pkg::POS_W'(f) << 16;
         end
         spr_pkg::ACT_FADE: begin
            fade_len = (w.fade_length == 0) ? 20'd1 : w.fade_length;
            fade_left = fade_len;
         end
         default: play_tick(w);
      endcase
   endtask

   task automatic check_result(spr_pkg::rsp_type got);
      spr_pkg::rsp_type e;
      if (expected_results.size() == 0) begin
         $error("result word with nothing expected: %p", got);
         mismatches++;
         return;
      end
      e = expected_results.pop_front();
      if (got.out_left !== e.out_left) begin
         $error("out_left expected %0d actual %0d", e.out_left, got.out_left);
         mismatches++;
      end
      if (got.out_right !== e.out_right) begin
         $error("out_right expected %0d actual %0d", e.out_right, got.out_right);
         mismatches++;
      end
      if (got.block_rms !== e.block_rms) begin
         $error("block_rms expected %0d actual %0d", e.block_rms, got.block_rms);
         mismatches++;
      end
      if (got.block_peak !== e.block_peak) begin
         $error("block_peak expected %0d actual %0d", e.block_peak, got.block_peak);
         mismatches++;
      end
      if (got.block_end !== e.block_end) begin
         $error("block_end expected %0d actual %0d", e.block_end, got.block_end);
         mismatches++;
      end
   endtask

   initial begin
      mismatches = 0;
      pending = 0;
      clear_state();
   end

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
      end else begin
         if (csr_valid && csr_ready) write_reg(csr_index, csr_data);
         if (req_valid && req_ready) take_word(req_data);
         if (rsp_valid && rsp_ready) check_result(rsp_data);
      end
      pending = expected_results.size();
   end

endmodule

[test/tb_top.sv]
// Top of the sample player testbench: clock, reset, word and register stimulus
// with random idling, and the verdict. Depends on spr_pkg, spr_checker and
// sample_player_resampler.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FILLED   = 256;    // frames 0..FILLED-1 always hold data
   localparam int SETTLE   = 300;
   localparam int WATCHDOG = 5000;
   localparam int REQ_W    = $bits(spr_pkg::req_type);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   spr_pkg::req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   spr_pkg::rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_data = '0;
   int          mismatches, pending;
   bit          idle_on = 1'b1;
   bit          hold_rsp = 1'b0;
   int          quiet_cycles = 0;

   sample_player_resampler u_dut (.*);

   spr_checker u_checker (.*);

   initial forever #5 clock = ~clock;

   // result side: random stalls, plus one long hold on request
   initial begin
      repeat (6) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (500) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (idle_on && $urandom_range(0, 11) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("tb_top failed");
         $finish;
      end
   end

   task automatic send_word(spr_pkg::req_type w);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic set_reg(logic [2:0] idx, logic [23:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic configure(logic [23:0] ratio, logic [23:0] decoded, logic [23:0] total,
                            logic [23:0] loaded, logic [23:0] fade);
      drain();
      set_reg(spr_pkg::REG_RATIO, ratio);
      set_reg(spr_pkg::REG_DECODED, decoded);
      set_reg(spr_pkg::REG_TOTAL, total);
      set_reg(spr_pkg::REG_LOADED, loaded);
      set_reg(spr_pkg::REG_FADE, fade);
   endtask

   function automatic spr_pkg::req_type make_word(spr_pkg::action_type act, int frame,
                                                  logic [1:0] tr, bit track, int g,
                                                  int fade, bit last);
      spr_pkg::req_type w;
      w.action = act;
      w.frame_index = 18'(frame);
      w.sample_left = 16'($urandom);
      w.sample_right = 16'($urandom);
      w.transport = tr;
      w.has_track = track;
      w.gain = 16'(g);
      w.fade_length = 20'(fade);
      w.last_in_block = last;
      return w;
   endfunction

   function automatic spr_pkg::req_type random_word();
      spr_pkg::req_type w;
      int dice;
      w = spr_pkg::req_type'(REQ_W'({$urandom, $urandom, $urandom}));
      dice = $urandom_range(0, 99);
      if (dice < 10) begin
         w.action = spr_pkg::ACT_WRITE;
         if ($urandom_range(0, 4) != 0) w.frame_index = 18'($urandom_range(0, FILLED - 1));
      end else if (dice < 20) begin
         w.action = spr_pkg::ACT_SEEK;
         if ($urandom_range(0, 3) != 0) w.frame_index = 18'($urandom_range(0, 300));
      end else if (dice < 28) begin
         w.action = spr_pkg::ACT_FADE;
         if ($urandom_range(0, 3) != 0) w.fade_length = 20'($urandom_range(0, 40));
      end else begin
         w.action = spr_pkg::ACT_TICK;
         w.has_track = ($urandom_range(0, 9) != 0);
         w.last_in_block = ($urandom_range(0, 15) == 0);
      end
      return w;
   endfunction

   task automatic random_run(int count);
      for (int i = 0; i < count; i++) send_word(random_word());
   endtask

   initial begin
      spr_pkg::req_type w;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // load the readable region, extremes in the first frames
      for (int f = 0; f < FILLED; f++) begin
         w = make_word(spr_pkg::ACT_WRITE, f, spr_pkg::TR_STOPPED, 1, 0, 0, 0);
         if (f == 0) begin
            w.sample_left = 16'sh7fff;
            w.sample_right = 16'sh8000;
         end else if (f == 1) begin
            w.sample_left = 16'sh8000;
            w.sample_right = 16'sh7fff;
         end
         send_word(w);
      end
      send_word(make_word(spr_pkg::ACT_WRITE, 262143, spr_pkg::TR_STOPPED, 1, 0, 0, 0));

      configure(24'd65536, 24'd64, 24'd64, 24'd1, 24'd9600);
      send_word(make_word(spr_pkg::ACT_SEEK, 0, spr_pkg::TR_STOPPED, 1, 0, 0, 0));
      send_word(make_word(spr_pkg::ACT_TICK, 0, spr_pkg::TR_PLAYING, 1, 16384, 0, 0));
      send_word(make_word(spr_pkg::ACT_TICK, 0, spr_pkg::TR_STARTING, 1, 65535, 0, 0));
      send_word(make_word(spr_pkg::ACT_TICK, 0, spr_pkg::TR_STOPPED, 1, 65535, 0, 0));
      send_word(make_word(spr_pkg::ACT_TICK, 0, spr_pkg::TR_STOPPING, 1, 65535, 0, 0));
      send_word(make_word(spr_pkg::ACT_FADE, 0, spr_pkg::TR_STOPPED, 1, 0, 0, 0));
      send_word(make_word(spr_pkg::ACT_TICK, 0, spr_pkg::TR_STOPPING, 1, 65535, 0, 0));
      send_word(make_word(spr_pkg::ACT_TICK, 0, spr_pkg::TR_STOPPING, 1, 65535, 0, 0));
      send_word(make_word(spr_pkg::ACT_FADE, 0, spr_pkg::TR_STOPPED, 1, 0, 3, 0));
      for (int i = 0; i < 3; i++)
         send_word(make_word(spr_pkg::ACT_TICK, 0, spr_pkg::TR_STOPPING, 1, 40000, 0, 0));
      send_word(make_word(spr_pkg::ACT_TICK, 0, spr_pkg::TR_PLAYING, 0, 65535, 0, 0));
      send_word(make_word(spr_pkg::ACT_TICK, 0, spr_pkg::TR_PLAYING, 1, 0, 0, 1));
      send_word(make_word(spr_pkg::ACT_SEEK, 1000, spr_pkg::TR_STOPPED, 1, 0, 0, 0));
      send_word(make_word(spr_pkg::ACT_TICK, 0, spr_pkg::TR_PLAYING, 1, 16384, 0, 0));
      send_word(make_word(spr_pkg::ACT_SEEK, 63, spr_pkg::TR_STOPPED, 1, 0, 0, 0));
      send_word(make_word(spr_pkg::ACT_TICK, 0, spr_pkg::TR_PLAYING, 1, 65535, 0, 0));
      send_word(make_word(spr_pkg::ACT_TICK, 0, spr_pkg::TR_PLAYING, 1, 65535, 1048575, 1));
      random_run(350);

      configure(24'hffffff, 24'd256, 24'd262144, 24'd1, 24'd1048575);
      random_run(200);

      configure(24'($urandom_range(0, 200000)), 24'($urandom_range(1, FILLED)),
                24'($urandom_range(1, 300)), 24'd1, 24'd1);
      random_run(100);
      hold_rsp = 1'b1;
      random_run(80);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      random_run(200);

      // no audio: seek ignored, outputs zero, block ends still marked
      configure(24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
      send_word(make_word(spr_pkg::ACT_SEEK, 5, spr_pkg::TR_STOPPED, 1, 0, 0, 0));
      for (int i = 0; i < 40; i++)
         send_word(make_word(spr_pkg::ACT_TICK, 0, spr_pkg::TR_PLAYING, 1, 65535, 0,
                             (i % 10) == 9));

      configure(24'd65536, 24'd262144, 24'd262144, 24'd0, 24'd20);
      random_run(80);
      configure(24'($urandom_range(0, 100000)), 24'd200, 24'd200, 24'd1, 24'd50);
      idle_on = 1'b0;
      random_run(170);

      drain();
      if (mismatches == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
